/* src/lpae_pkg.sv */
// ----------------------------------------------------------------------------
// Line position angle estimator package
// Shared types and constants for the estimator and its channel interfaces.
// ----------------------------------------------------------------------------
package lpae_pkg;

    localparam int SAMPLE_W    = 11;
    localparam int ANGLE_W     = 14;
    localparam int STATUS_W    = 2;
    localparam int STATE_W     = 16;
    localparam int CORDIC_W    = 48;
    localparam int Z_W         = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W      = 4;
    localparam logic signed [STATE_W-1:0] HOLD_ANGLE  = 16'sd7680;
    localparam logic signed [STATE_W-1:0] LARGE_ANGLE = 16'sd256;
    localparam logic [10:0] RADIUS_TENTHS = 11'd1275;

    typedef enum logic [1:0] {
        STATUS_TRACKED  = 2'd0,
        STATUS_CROSSING = 2'd1,
        STATUS_FLAT     = 2'd2,
        STATUS_NO_WEIGHT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WEIGH,
        ST_CORDIC,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
    } frame_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [STATUS_W-1:0]       status;
        logic                      restart_ignore_timer;
    } result_t;

    // Arctangent of 2^-i in degrees, Q.16, rounded to nearest.
    function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [Z_W-1:0] v;
        case (i)
            4'd0:    v = 24'd2949120;
            4'd1:    v = 24'd1740967;
            4'd2:    v = 24'd919879;
            4'd3:    v = 24'd466945;
            4'd4:    v = 24'd234379;
            4'd5:    v = 24'd117304;
            4'd6:    v = 24'd58666;
            4'd7:    v = 24'd29335;
            4'd8:    v = 24'd14668;
            4'd9:    v = 24'd7334;
            4'd10:   v = 24'd3667;
            4'd11:   v = 24'd1833;
            4'd12:   v = 24'd917;
            4'd13:   v = 24'd458;
            4'd14:   v = 24'd229;
            default: v = 24'd115;
        endcase
        return v;
    endfunction

endpackage

/* src/lpae_if.sv */
// ----------------------------------------------------------------------------
// Line position angle estimator channels
// Valid/ready channels that carry a sensor frame and an angle result.
// ----------------------------------------------------------------------------
interface lpae_frame_if;
    logic             valid;
    logic             ready;
    lpae_pkg::frame_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lpae_result_if;
    logic              valid;
    logic              ready;
    lpae_pkg::result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/line_position_angle_estimator.sv */
// ----------------------------------------------------------------------------
// Line position angle estimator
// Weighted centroid of a reflectance bar, turned into a line angle by CORDIC.
// ----------------------------------------------------------------------------
// One request is a frame of SENSORS reflectance fractions. It yields exactly
// one result with the line angle in degrees (signed Q6.8), a status code and
// the ignore-timer restart flag. The block works on one frame at a time.
// After a frame is taken, a sequencer makes three passes over the sensors,
// one sensor per cycle. The first pass finds the minimum, the maximum and
// the over-tolerance count. The second pass marks the active sensors and
// detects a split line. The third pass masks and accumulates the weighted
// sum, with one 11x10 multiply per sensor. Then one shared shift/add CORDIC
// stage runs for 16 iterations, followed by a finishing step and an output
// step that posts the result. Crossing and flat frames skip the later
// steps. The result sits in an output register until it is taken. A new
// frame is accepted once that register is free and the sequencer is idle,
// which is the cycle after the result is taken. The tolerance register may
// be written while no frame is in flight.
// ----------------------------------------------------------------------------
module line_position_angle_estimator #(
    parameter int SENSORS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lpae_pkg::SAMPLE_W-1:0]     cfg_wdata,
    lpae_frame_if.sink                        frame,
    lpae_result_if.source                     result
);
    import lpae_pkg::*;

    localparam int HALF  = SENSORS / 2;
    localparam int IDX_W = $clog2(SENSORS + 1);
    localparam int SEL_W = $clog2(SENSORS);

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] tol_reg;
    logic [SAMPLE_W-1:0] samp_reg [SENSORS];
    logic [IDX_W-1:0]    idx_reg;
    logic [SAMPLE_W-1:0] lo_reg, hi_reg;
    logic [IDX_W-1:0]    count_reg;
    logic                any_reg, split_reg, gap_reg;
    logic [SENSORS-1:0]  act_reg;
    logic signed [STATE_W-1:0] prev_reg, large_reg;
    logic signed [31:0]  num_reg;
    logic [15:0]         den_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [Z_W+1:0] z_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic [SAMPLE_W-1:0] frame_s [8];
    assign frame_s[0] = frame.payload.sample_0;
    assign frame_s[1] = frame.payload.sample_1;
    assign frame_s[2] = frame.payload.sample_2;
    assign frame_s[3] = frame.payload.sample_3;
    assign frame_s[4] = frame.payload.sample_4;
    assign frame_s[5] = frame.payload.sample_5;
    assign frame_s[6] = frame.payload.sample_6;
    assign frame_s[7] = frame.payload.sample_7;

    logic take;
    assign frame.ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign take         = frame.valid && frame.ready;
    assign result.valid = out_valid_reg;
    assign result.payload = out_reg;

    // Current sensor under the sequencer.
    logic [SEL_W-1:0]    sel;
    logic [SAMPLE_W-1:0] cur;
    logic [IDX_W-1:0]    last_idx;
    assign sel      = (idx_reg < IDX_W'(SENSORS)) ? idx_reg[SEL_W-1:0] : '0;
    assign cur      = samp_reg[sel];
    assign last_idx = IDX_W'(SENSORS - 1);

    // Scan-phase decisions.
    logic crossing, flat;
    assign crossing = count_reg >= IDX_W'(HALF + 1);
    assign flat     = ({1'b0, hi_reg} - {1'b0, lo_reg}) < {1'b0, tol_reg};

    logic signed [STATE_W-1:0] hold;
    assign hold = (large_reg > 0) ? HOLD_ANGLE : -HOLD_ANGLE;

    // Weigh-phase: sensor is active when it stands clear of the minimum.
    logic        cur_active;
    logic        masked;
    logic        lost;
    logic [9:0]  weight;
    logic        left;
    logic signed [31:0] prod;
    assign cur_active = ({1'b0, cur} - {1'b0, lo_reg}) >= {1'b0, tol_reg};
    assign left   = idx_reg < IDX_W'(HALF);
    assign lost   = (prev_reg >= HOLD_ANGLE) || (prev_reg <= -HOLD_ANGLE);
    always_comb
    begin
        weight = '0;
        if (left)
            weight = 10'(80 * (HALF - 1) + 46) - 10'({idx_reg, 6'b0} + {idx_reg, 4'b0});
        else if (idx_reg < IDX_W'(2 * HALF))
            weight = 10'(46) + 10'({idx_reg - IDX_W'(HALF), 6'b0})
                   + 10'({idx_reg - IDX_W'(HALF), 4'b0});
    end
    assign prod = $signed(32'(20'(cur) * 20'(weight)));

    // Masking uses the split flag, known only after all sensors were seen, so
    // the accumulation pass runs on the activity bits collected in the weigh pass.
    logic act_cur;
    assign act_cur = act_reg[sel];
    always_comb
    begin
        masked = !act_cur;
        if (lost || split_reg)
        begin
            if (prev_reg > 0)
                masked = masked || left;
            else
                masked = masked || !left;
        end
    end

    // CORDIC stage.
    logic signed [CORDIC_W-1:0] xs, ys;
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    logic signed [Z_W+1:0] at;
    assign at = $signed({2'b00, atan_entry(step_reg)});

    logic signed [Z_W+1:0] zr;
    logic signed [STATE_W-1:0] mag_angle, final_angle;
    assign zr = (z_reg + 26'sd128) >>> 8;
    assign mag_angle = STATE_W'(zr);
    assign final_angle = num_reg < 0 ? -mag_angle : mag_angle;

    logic [31:0] num_mag;
    assign num_mag = num_reg < 0 ? 32'(-num_reg) : 32'(num_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (take) state_next = ST_SCAN;
            ST_SCAN:   if (idx_reg == last_idx) state_next = ST_WEIGH;
            ST_WEIGH:
            begin
                if (idx_reg == IDX_W'(0) && (crossing || flat))
                    state_next = ST_OUT;
                else if (idx_reg == last_idx)
                    state_next = ST_CORDIC;
            end
            ST_CORDIC: if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Accumulation pass (CORDIC setup) sums with the current sensor included.
    logic signed [31:0] num_acc;
    logic [15:0]        den_acc;
    always_comb
    begin
        num_acc = num_reg;
        den_acc = den_reg;
        if (!masked && idx_reg < IDX_W'(2 * HALF))
        begin
            num_acc = left ? num_reg - prod : num_reg + prod;
            den_acc = den_reg + 16'(cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= 11'd205;
            prev_reg      <= '0;
            large_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        for (int i = 0; i < SENSORS; i++)
                            samp_reg[i] <= frame_s[i];
                        idx_reg   <= '0;
                        lo_reg    <= 11'd2047;
                        hi_reg    <= '0;
                        count_reg <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (cur < lo_reg) lo_reg <= cur;
                    if (cur > hi_reg) hi_reg <= cur;
                    if (cur > tol_reg) count_reg <= count_reg + 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        idx_reg   <= '0;
                        any_reg   <= 1'b0;
                        split_reg <= 1'b0;
                        gap_reg   <= 1'b0;
                        num_reg   <= '0;
                        den_reg   <= '0;
                        act_reg   <= '0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_WEIGH:
                begin
                    if (idx_reg == IDX_W'(0) && crossing)
                    begin
                        out_reg <= '{angle: '0, status: STATUS_CROSSING,
                                     restart_ignore_timer: 1'b0};
                    end
                    else if (idx_reg == IDX_W'(0) && flat)
                    begin
                        out_reg <= '{angle: ANGLE_W'(hold), status: STATUS_FLAT,
                                     restart_ignore_timer: !lost};
                        prev_reg <= hold;
                    end
                    else
                    begin
                        // This pass collects activity and split;
                        // accumulation is done in the CORDIC setup.
                        if (cur_active)
                        begin
                            act_reg[sel] <= 1'b1;
                            if (any_reg && gap_reg) split_reg <= 1'b1;
                            any_reg <= 1'b1;
                        end
                        else if (any_reg)
                            gap_reg <= 1'b1;
                        if (idx_reg == last_idx)
                        begin
                            idx_reg  <= '0;
                            step_reg <= '0;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_CORDIC:
                begin
                    // The first SENSORS steps accumulate the weighted sums,
                    // then the CORDIC iterations run on the shared adder.
                    if (idx_reg < IDX_W'(SENSORS))
                    begin
                        num_reg <= num_acc;
                        den_reg <= den_acc;
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == last_idx)
                        begin
                            x_reg <= CORDIC_W'(32'(den_acc) * 32'(RADIUS_TENTHS)) <<< 8;
                            y_reg <= CORDIC_W'(num_acc < 0 ? 32'(-num_acc) : 32'(num_acc))
                                     <<< 8;
                            z_reg <= '0;
                        end
                    end
                    else
                    begin
                        if (y_reg >= 0)
                        begin
                            x_reg <= x_reg + ys;
                            y_reg <= y_reg - xs;
                            z_reg <= z_reg + at;
                        end
                        else
                        begin
                            x_reg <= x_reg - ys;
                            y_reg <= y_reg + xs;
                            z_reg <= z_reg - at;
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (den_reg == '0)
                    begin
                        out_reg <= '{angle: ANGLE_W'(hold), status: STATUS_NO_WEIGHT,
                                     restart_ignore_timer: split_reg};
                        prev_reg <= hold;
                    end
                    else
                    begin
                        logic signed [STATE_W-1:0] a;
                        a = (num_mag == '0) ? '0 : final_angle;
                        out_reg <= '{angle: ANGLE_W'(a), status: STATUS_TRACKED,
                                     restart_ignore_timer: split_reg};
                        prev_reg <= a;
                        if (a > LARGE_ANGLE || a < -LARGE_ANGLE)
                            large_reg <= a;
                    end
                end
                ST_OUT:
                    out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule
